// ===== sv/gbn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    // field widths
    localparam int CHUNK_W = 20;
    localparam int BYTES_W = 11;
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 1;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // defaults and fixed values
    localparam int DEFAULT_WINDOW = 8;
    localparam logic [BYTES_W-1:0] CHUNK_FULL = 11'd1494;
    localparam logic [CHUNK_W-1:0] TOTAL_RESET = 20'd1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TOTAL_CHUNKS     = 1'd0;
    localparam logic [IDX_W-1:0] REG_LAST_CHUNK_BYTES = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_ISSUE,
        ST_DONE
    } gbn_state_t;

    // which issue range to load
    typedef enum logic [1:0] {
        RNG_START,
        RNG_ACK,
        RNG_TIMEOUT
    } rng_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     load_range;
        rng_sel_t range_sel;
        logic     start_run;
        logic     zero_start;
        logic     ack_commit;
        logic     stop;
        logic     bound;
        logic     emit_chunk;
        logic     emit_done;
    } gbn_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             running;
        logic             total_zero;
        logic             ack_stale;
        logic             ack_beyond;
        logic             ack_final;
        logic             range_empty;
        logic             at_end;
        logic             slot_free;
    } gbn_status_t;

endpackage

`default_nettype wire

// ===== sv/gbn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbn_ctrl
    import gbn_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire gbn_status_t status,
    output gbn_cmd_t         cmd
);

    gbn_state_t state_reg;
    gbn_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.range_sel  = RNG_START;
        s_axis_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                state_next = ST_IDLE;
                case (status.action)
                    ACT_START:
                    begin
                        if (status.total_zero)
                        begin
                            cmd.zero_start = 1'b1;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            cmd.start_run  = 1'b1;
                            cmd.load_range = 1'b1;
                            cmd.range_sel  = RNG_START;
                            state_next     = ST_BOUND;
                        end
                    end
                    ACT_ACK:
                    begin
                        if (status.running && !status.ack_stale)
                        begin
                            if (status.ack_beyond)
                            begin
                                cmd.load_range = 1'b1;
                                cmd.range_sel  = RNG_TIMEOUT;
                                state_next     = ST_BOUND;
                            end
                            else if (status.ack_final)
                            begin
                                cmd.ack_commit = 1'b1;
                                cmd.stop       = 1'b1;
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                cmd.ack_commit = 1'b1;
                                cmd.load_range = 1'b1;
                                cmd.range_sel  = RNG_ACK;
                                state_next     = ST_BOUND;
                            end
                        end
                    end
                    ACT_TIMEOUT:
                    begin
                        if (status.running)
                        begin
                            cmd.load_range = 1'b1;
                            cmd.range_sel  = RNG_TIMEOUT;
                            state_next     = ST_BOUND;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_BOUND:
            begin
                cmd.bound  = 1'b1;
                state_next = status.range_empty ? ST_IDLE : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_chunk = 1'b1;
                    if (status.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/gbn_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire  [IDX_W-1:0]       cfg_index,
    input  wire  [CHUNK_W-1:0]     cfg_data,
    input  wire  [S_TDATA_W-1:0]   s_axis_tdata,
    input  wire  [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  wire gbn_cmd_t          cmd,
    output gbn_status_t            status
);

    localparam logic [CHUNK_W:0] WIN_EXT = (CHUNK_W + 1)'(WINDOW);

    // configuration
    logic [CHUNK_W-1:0] total_reg;
    logic [BYTES_W-1:0] lcb_reg;

    // latched input beat
    logic [ACT_W-1:0]   act_reg;
    logic [CHUNK_W-1:0] ack_reg;

    // window state
    logic [CHUNK_W-1:0] acked_reg;
    logic [CHUNK_W-1:0] high_reg;
    logic               running_reg;

    // issue range
    logic [CHUNK_W:0]   cur_reg;
    logic [CHUNK_W-1:0] end_reg;

    // output beat
    logic               out_valid_reg;
    logic [CHUNK_W-1:0] out_chunk_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic               out_done_reg;
    logic               out_last_reg;

    logic [CHUNK_W:0]   base;
    logic [CHUNK_W:0]   sum;
    logic [CHUNK_W-1:0] end_calc;
    logic [CHUNK_W:0]   cur_calc;
    logic [BYTES_W-1:0] last_bytes;
    logic [BYTES_W-1:0] chunk_bytes;
    logic               slot_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            lcb_reg   <= CHUNK_FULL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL_CHUNKS:     total_reg <= cfg_data;
                REG_LAST_CHUNK_BYTES: lcb_reg   <= cfg_data[BYTES_W-1:0];
                default:              lcb_reg   <= lcb_reg;
            endcase
        end
    end

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg <= s_axis_tuser;
            ack_reg <= s_axis_tdata[CHUNK_W-1:0];
        end
    end

    // range start and capped end
    always_comb
    begin
        case (cmd.range_sel)
            RNG_START:
            begin
                base     = '0;
                cur_calc = (CHUNK_W + 1)'(1);
            end
            RNG_ACK:
            begin
                base     = {1'b0, ack_reg};
                cur_calc = {1'b0, high_reg} + (CHUNK_W + 1)'(1);
            end
            default:
            begin
                base     = {1'b0, acked_reg};
                cur_calc = {1'b0, acked_reg} + (CHUNK_W + 1)'(1);
            end
        endcase
        sum      = base + WIN_EXT;
        end_calc = (sum > {1'b0, total_reg}) ? total_reg : sum[CHUNK_W-1:0];
    end

    // window state and range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg   <= '0;
            high_reg    <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_run || cmd.zero_start)
            begin
                acked_reg   <= '0;
                high_reg    <= '0;
                running_reg <= cmd.start_run;
            end
            if (cmd.ack_commit)
            begin
                acked_reg <= ack_reg;
            end
            if (cmd.stop)
            begin
                running_reg <= 1'b0;
            end
            if (cmd.bound && (end_reg > high_reg))
            begin
                high_reg <= end_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_range)
        begin
            cur_reg <= cur_calc;
            end_reg <= end_calc;
        end
        else if (cmd.emit_chunk)
        begin
            cur_reg <= cur_reg + (CHUNK_W + 1)'(1);
        end
    end

    // byte count of the current chunk
    always_comb
    begin
        if ((lcb_reg == '0) || (lcb_reg > CHUNK_FULL))
        begin
            last_bytes = CHUNK_FULL;
        end
        else
        begin
            last_bytes = lcb_reg;
        end
        chunk_bytes = (cur_reg == {1'b0, total_reg}) ? last_bytes : CHUNK_FULL;
    end

    assign slot_free = !out_valid_reg || m_axis_tready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_chunk || cmd.emit_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_chunk)
        begin
            out_chunk_reg <= cur_reg[CHUNK_W-1:0];
            out_bytes_reg <= chunk_bytes;
            out_done_reg  <= 1'b0;
            out_last_reg  <= (cur_reg == {1'b0, end_reg});
        end
        else if (cmd.emit_done)
        begin
            out_chunk_reg <= '0;
            out_bytes_reg <= '0;
            out_done_reg  <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_bytes_reg, out_chunk_reg};
    assign m_axis_tuser  = out_done_reg;
    assign m_axis_tlast  = out_last_reg;

    // status to the controller
    always_comb
    begin
        status.action      = act_reg;
        status.running     = running_reg;
        status.total_zero  = (total_reg == '0);
        status.ack_stale   = (ack_reg <= acked_reg);
        status.ack_beyond  = (ack_reg > high_reg);
        status.ack_final   = (ack_reg >= total_reg);
        status.range_empty = (cur_reg > {1'b0, end_reg});
        status.at_end      = (cur_reg == {1'b0, end_reg});
        status.slot_free   = slot_free;
    end

endmodule

`default_nettype wire

// ===== sv/go_back_n_send_window.sv =====
// Go-back-N send window: turns transfer events into the list of chunks to send.
// Input stream: one beat per event; tuser holds the action (start, ack,
// timeout), tdata the cumulative ack number. Output stream: one beat per
// chunk to send, with chunk number and byte count in tdata, a done flag in
// tuser and tlast on the final beat caused by an event.
// The configuration port sets the chunk total and the size of the last chunk;
// write it only between events.
// Sequence: an event is taken in IDLE, classified in CLASSIFY and its window
// bound is settled in BOUND; then ISSUE produces one chunk beat per cycle
// while the output slot is free, up to WINDOW beats, counted by the single
// issue counter in the datapath. A start with a zero chunk total or a final
// ack goes to DONE, which gives the done beat; events that cause no beat
// return to IDLE from CLASSIFY or BOUND.
// The output register lets the next event be taken while the last beat
// still waits downstream.
// Reset clears the window, leaves the block idle (not running) and sets the
// chunk total to 1 and the last chunk size to a full chunk.
// When the receiver stalls, the current beat holds and chunk issue pauses.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_send_window
    import gbn_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    // configuration
    input  wire                  cfg_we,
    input  wire  [IDX_W-1:0]     cfg_index,
    input  wire  [CHUNK_W-1:0]   cfg_data,
    // event stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,   // ack_number[19:0], zero pad
    input  wire  [ACT_W-1:0]     s_axis_tuser,   // action[1:0]
    // chunk stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // chunk_number[19:0], byte_count[30:20], pad
    output logic                 m_axis_tuser,   // done_res
    output logic                 m_axis_tlast    // last_of_run
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    // sequencer
    gbn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // window state, issue counter and output register
    gbn_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire
